@@ rtl/core/fbcm_pkg.sv @@
// ----------------------------------------------------------------------------
// fbcm_pkg
// Types and fixed constants shared by the block change map files.
// ----------------------------------------------------------------------------
`default_nettype none

package fbcm_pkg;

  localparam int FLAG_WORD_BITS = 32;
  localparam int RESULT_LIMIT   = 8;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int LINE_W         = 12;
  localparam int HEIGHT_W       = 13;
  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int ROW_W          = 8;
  localparam int WORD_IDX_W     = 3;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [31:0] previous_pixel;
    logic [31:0] current_pixel;
    logic        frame_start;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]          block_row;
    logic [WORD_IDX_W-1:0]     word_index;
    logic [FLAG_WORD_BITS-1:0] dirty_flags;
    logic                      last_of_row;
    logic                      frame_done;
  } out_item_t;

  // side info of one captured block row
  typedef struct packed {
    logic [WORD_IDX_W-1:0] last_word;
    logic [ROW_W-1:0]      block_row;
    logic                  frame_done;
  } snap_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/fbcm_track.sv @@
// ----------------------------------------------------------------------------
// fbcm_track
// Raster position tracking, per-block dirty flags and block row capture.
// ----------------------------------------------------------------------------
`default_nettype none

module fbcm_track
  import fbcm_pkg::*;
#(
  parameter int BLOCK_SIZE = 16,
  parameter int MAX_WIDTH  = 4096,
  parameter int SLOTS      = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE,
  parameter int SNAP_BITS  = 256,
  parameter int WEFF_W     = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  input  wire in_item_t             item,
  input  wire logic [WEFF_W-1:0]    w_eff,
  input  wire logic [HEIGHT_W-1:0]  h_eff,
  input  wire logic                 snap_free,
  output logic                      item_take,
  output logic                      snap_load,
  output logic [SNAP_BITS-1:0]      snap_flags,
  output snap_ctrl_t                snap_ctrl
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CX_W  = $clog2(BLOCK_SIZE);
  localparam int BX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CX_W-1:0]   cx_r, cx_nxt;
  logic [BX_W-1:0]   bx_r, bx_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [CX_W-1:0]   ly_r, ly_nxt;
  logic [ROW_W-1:0]  by_r, by_nxt;
  logic [SLOTS-1:0]  dirty_r, dirty_nxt;

  logic [COL_W-1:0]    col0, col1;
  logic [CX_W-1:0]     cx0, cx1, ly0, ly1, ly2;
  logic [BX_W-1:0]     bx0, bx1;
  logic [HEIGHT_W-1:0] line0, line1, line2, line3;
  logic [ROW_W-1:0]    by0, by1, by2;
  logic [WEFF_W-1:0]   col_inc;
  logic                wrap_col, wrap_line, row_end, last_line, pix_diff;
  logic [SLOTS-1:0]    dirty_base, dirty_eff;
  logic [15:0]         word_pos;

  always_comb begin
    // frame start restarts the raster
    col0  = item.frame_start ? '0 : col_r;
    cx0   = item.frame_start ? '0 : cx_r;
    bx0   = item.frame_start ? '0 : bx_r;
    line0 = item.frame_start ? '0 : HEIGHT_W'(line_r);
    ly0   = item.frame_start ? '0 : ly_r;
    by0   = item.frame_start ? '0 : by_r;

    // width shrank under a running line
    wrap_col = WEFF_W'(col0) >= w_eff;
    col1  = wrap_col ? '0 : col0;
    cx1   = wrap_col ? '0 : cx0;
    bx1   = wrap_col ? '0 : bx0;
    line1 = wrap_col ? line0 + 1'b1 : line0;
    ly1   = ly0;
    by1   = by0;
    if (wrap_col) begin
      if (ly0 == CX_W'(BLOCK_SIZE - 1)) begin
        ly1 = '0;
        by1 = by0 + 1'b1;
      end else begin
        ly1 = ly0 + 1'b1;
      end
    end

    // height shrank under a running frame
    wrap_line = line1 >= h_eff;
    line2 = wrap_line ? '0 : line1;
    ly2   = wrap_line ? '0 : ly1;
    by2   = wrap_line ? '0 : by1;

    last_line = line2 == h_eff - 1'b1;
    row_end   = (WEFF_W'(col1) == w_eff - 1'b1) &&
                ((ly2 == CX_W'(BLOCK_SIZE - 1)) || last_line);
    pix_diff  = item.previous_pixel != item.current_pixel;

    dirty_base = item.frame_start ? '0 : dirty_r;
  end

  for (genvar j = 0; j < SLOTS; j++) begin : g_dirty
    assign dirty_eff[j] = dirty_base[j] | (pix_diff && (bx1 == BX_W'(j)));
  end

  for (genvar j = 0; j < SNAP_BITS; j++) begin : g_snap
    if (j < SLOTS) begin : g_in
      assign snap_flags[j] = dirty_eff[j] && (BX_W'(j) <= bx1);
    end else begin : g_out
      assign snap_flags[j] = 1'b0;
    end
  end

  always_comb begin
    item_take = item_valid && (!row_end || snap_free);
    snap_load = item_take && row_end;

    word_pos = 16'(bx1) >> $clog2(FLAG_WORD_BITS);
    snap_ctrl.last_word  = (word_pos > 16'(RESULT_LIMIT - 1)) ?
                           WORD_IDX_W'(RESULT_LIMIT - 1) : word_pos[WORD_IDX_W-1:0];
    snap_ctrl.block_row  = by2;
    snap_ctrl.frame_done = last_line;
  end

  // advance to the next pixel position
  always_comb begin
    col_inc  = WEFF_W'(col1) + 1'b1;
    col_nxt  = col_r;
    cx_nxt   = cx_r;
    bx_nxt   = bx_r;
    line_nxt = line_r;
    ly_nxt   = ly_r;
    by_nxt   = by_r;
    dirty_nxt = dirty_r;
    line3    = line2;
    if (item_take) begin
      dirty_nxt = row_end ? '0 : dirty_eff;
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        cx_nxt  = '0;
        bx_nxt  = '0;
        line3   = line2 + 1'b1;
        if (line3 >= h_eff) begin
          line_nxt = '0;
          ly_nxt   = '0;
          by_nxt   = '0;
        end else begin
          line_nxt = line3[LINE_W-1:0];
          if (ly2 == CX_W'(BLOCK_SIZE - 1)) begin
            ly_nxt = '0;
            by_nxt = by2 + 1'b1;
          end else begin
            ly_nxt = ly2 + 1'b1;
            by_nxt = by2;
          end
        end
      end else begin
        col_nxt  = col_inc[COL_W-1:0];
        line_nxt = line2[LINE_W-1:0];
        ly_nxt   = ly2;
        by_nxt   = by2;
        if (cx1 == CX_W'(BLOCK_SIZE - 1)) begin
          cx_nxt = '0;
          bx_nxt = bx1 + 1'b1;
        end else begin
          cx_nxt = cx1 + 1'b1;
          bx_nxt = bx1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      cx_r    <= '0;
      bx_r    <= '0;
      line_r  <= '0;
      ly_r    <= '0;
      by_r    <= '0;
      dirty_r <= '0;
    end else begin
      col_r   <= col_nxt;
      cx_r    <= cx_nxt;
      bx_r    <= bx_nxt;
      line_r  <= line_nxt;
      ly_r    <= ly_nxt;
      by_r    <= by_nxt;
      dirty_r <= dirty_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fbcm_emit.sv @@
// ----------------------------------------------------------------------------
// fbcm_emit
// Holds one captured block row and sends it out one flag word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module fbcm_emit
  import fbcm_pkg::*;
#(
  parameter int SNAP_BITS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 snap_load,
  input  wire logic [SNAP_BITS-1:0] snap_flags,
  input  wire snap_ctrl_t           snap_ctrl,
  output logic                      snap_free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data
);

  logic                  busy_r, busy_nxt;
  logic [SNAP_BITS-1:0]  buf_r, buf_nxt;
  logic [WORD_IDX_W-1:0] k_r, k_nxt;
  snap_ctrl_t            ctrl_r, ctrl_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic                  move, last_move;

  always_comb begin
    move      = busy_r && (!out_valid_r || out_ready);
    last_move = move && (k_r == ctrl_r.last_word);
    snap_free = !busy_r || last_move;

    busy_nxt      = busy_r;
    buf_nxt       = buf_r;
    k_nxt         = k_r;
    ctrl_nxt      = ctrl_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (move) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.block_row   = ctrl_r.block_row;
      out_data_nxt.word_index  = k_r;
      out_data_nxt.dirty_flags = buf_r[FLAG_WORD_BITS-1:0];
      out_data_nxt.last_of_row = k_r == ctrl_r.last_word;
      out_data_nxt.frame_done  = ctrl_r.frame_done;
      buf_nxt                  = buf_r >> FLAG_WORD_BITS;
      k_nxt                    = k_r + 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (snap_load) begin
      busy_nxt = 1'b1;
      buf_nxt  = snap_flags;
      k_nxt    = '0;
      ctrl_nxt = snap_ctrl;
    end else if (last_move) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    buf_r      <= buf_nxt;
    k_r        <= k_nxt;
    ctrl_r     <= ctrl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/frame_block_change_map.sv @@
// ----------------------------------------------------------------------------
// frame_block_change_map
// Block change map between a previous and a next frame, one pixel pair per
// request, dirty flags of each block row sent out as flag words.
// ----------------------------------------------------------------------------
// Pixel pairs arrive in raster order, one per request, and the block takes
// one per clock. A BLOCK_SIZE x BLOCK_SIZE block is flagged dirty when any of
// its pixels inside the image differs in any bit; partial edge blocks count.
// On the last pixel of a block row the row's flags are captured and sent as
// 1 to 8 words of 32 flags, lowest block first, one word per clock while the
// result side takes them. An item passes the input register, then the
// combinational position and flag logic. A row goes into the row buffer
// as its closing item is taken, its first word out via the result register.
// The only stall: a row-ending pixel waits in the input register while the
// previous row still has words in the row buffer. Widths are clamped to
// 1..MAX_WIDTH and heights to 1..4096; write the size registers only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_block_change_map
  import fbcm_pkg::*;
#(
  parameter int BLOCK_SIZE = 16,
  parameter int MAX_WIDTH  = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // block slots along a line and words per captured row
  localparam int SLOTS     = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int WORDS_ALL = (SLOTS + FLAG_WORD_BITS - 1) / FLAG_WORD_BITS;
  localparam int WORDS_MAX = (WORDS_ALL > RESULT_LIMIT) ? RESULT_LIMIT : WORDS_ALL;
  localparam int SNAP_BITS = WORDS_MAX * FLAG_WORD_BITS;
  localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);
  localparam int W_RESET   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  // clamped size registers
  logic [WEFF_W-1:0]   w_eff_r, w_eff_nxt;
  logic [HEIGHT_W-1:0] h_eff_r, h_eff_nxt;

  // input register
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;

  logic                 item_take, snap_load, snap_free;
  logic [SNAP_BITS-1:0] snap_flags;
  snap_ctrl_t           snap_ctrl;

  always_comb begin
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_wdata == '0) begin
            w_eff_nxt = WEFF_W'(1);
          end else if (14'(cfg_wdata) > 14'(MAX_WIDTH)) begin
            w_eff_nxt = WEFF_W'(MAX_WIDTH);
          end else begin
            w_eff_nxt = WEFF_W'(cfg_wdata);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_wdata == '0) begin
            h_eff_nxt = HEIGHT_W'(1);
          end else if (cfg_wdata > HEIGHT_W'(HEIGHT_LIMIT)) begin
            h_eff_nxt = HEIGHT_W'(HEIGHT_LIMIT);
          end else begin
            h_eff_nxt = cfg_wdata;
          end
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // input register frees when the tracker takes its item
  assign in_ready = !s1_valid_r || item_take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (item_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r    <= WEFF_W'(W_RESET);
      h_eff_r    <= HEIGHT_W'(RESET_HEIGHT);
      s1_valid_r <= 1'b0;
    end else begin
      w_eff_r    <= w_eff_nxt;
      h_eff_r    <= h_eff_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // position, flags and row capture
  fbcm_track #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_WIDTH  (MAX_WIDTH),
    .SLOTS      (SLOTS),
    .SNAP_BITS  (SNAP_BITS),
    .WEFF_W     (WEFF_W)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .w_eff      (w_eff_r),
    .h_eff      (h_eff_r),
    .snap_free  (snap_free),
    .item_take  (item_take),
    .snap_load  (snap_load),
    .snap_flags (snap_flags),
    .snap_ctrl  (snap_ctrl)
  );

  // row buffer and result register
  fbcm_emit #(
    .SNAP_BITS (SNAP_BITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_load  (snap_load),
    .snap_flags (snap_flags),
    .snap_ctrl  (snap_ctrl),
    .snap_free  (snap_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame block change map.
// ----------------------------------------------------------------------------
// Drives pixel pair requests through a valid/ready channel and checks every
// flag word against a running prediction of positions and dirty blocks. A
// scripted opening covers the reset height, clamped sizes, ignored register
// writes, a mid-frame resize and a mid-frame frame_start. A long receiver
// hold-off then fills the block. Random phases follow with random sizes and
// random gaps on both sides.
// ----------------------------------------------------------------------------

module tb;
  import fbcm_pkg::*;

  localparam int BLOCK_SIZE      = 16;
  localparam int MAX_WIDTH       = 4096;
  localparam int BLOCK_SLOTS     = MAX_WIDTH / BLOCK_SIZE;
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_CYCLES      = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_ITEMS  = 40;
  localparam int RANDOM_ITEMS    = 110;
  localparam int MAX_PRINTED     = 40;
  localparam int LIMIT_NS        = 5_000_000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {STEP_WRITE, STEP_PIXEL} step_kind_t;

  // one line of the opening script: a register write or a run of pixels
  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     reg_value;
    in_item_t             pixel;
    logic [15:0]          repeats;
    logic [1:0]           typed_count;
    out_item_t            typed_first;
    out_item_t            typed_second;
  } script_step_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // predicted block state, mirrored size registers
  logic [CFG_W-1:0]       width_setting;
  logic [CFG_W-1:0]       height_setting;
  int unsigned            column_at;
  int unsigned            line_at;
  logic [BLOCK_SLOTS-1:0] dirty_blocks;

  out_item_t    flag_words_due[$];
  script_step_t script[$];

  int unsigned random_pixels = 0;
  int unsigned mismatches    = 0;
  bit          steady_feed   = 1'b0;
  bit          hold_off_req  = 1'b0;

  always #1 clk = ~clk;

  frame_block_change_map #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_WIDTH  (MAX_WIDTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // sizes as the block uses them, out-of-range values clamped
  function automatic int unsigned active_width();
    if (width_setting == 0) return 1;
    if (width_setting > MAX_WIDTH) return MAX_WIDTH;
    return width_setting;
  endfunction

  function automatic int unsigned active_height();
    if (height_setting == 0) return 1;
    if (height_setting > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return height_setting;
  endfunction

  function automatic out_item_t make_word(input int unsigned row, input int unsigned idx,
                                          input logic [31:0] flags, input logic last,
                                          input logic done);
    out_item_t word;
    word.block_row   = row[ROW_W-1:0];
    word.word_index  = idx[WORD_IDX_W-1:0];
    word.dirty_flags = flags;
    word.last_of_row = last;
    word.frame_done  = done;
    return word;
  endfunction

  // advance position and dirty map by one pixel; queue the row's flag words
  // when this pixel closes a block row
  task automatic predict_pixel(input in_item_t px, input bit keep);
    int unsigned w, h, blocks, words, b, row;
    logic [31:0] flags;
    w      = active_width();
    h      = active_height();
    blocks = (w + BLOCK_SIZE - 1) / BLOCK_SIZE;
    if (px.frame_start) begin
      column_at    = 0;
      line_at      = 0;
      dirty_blocks = '0;
    end
    // size shrunk mid frame: fold onto the next line, then onto line 0
    if (column_at >= w) begin
      column_at = 0;
      line_at++;
    end
    if (line_at >= h) line_at = 0;
    if (px.previous_pixel != px.current_pixel) dirty_blocks[column_at / BLOCK_SIZE] = 1'b1;
    if (column_at == w - 1 && (line_at % BLOCK_SIZE == BLOCK_SIZE - 1 || line_at == h - 1)) begin
      words = (blocks + FLAG_WORD_BITS - 1) / FLAG_WORD_BITS;
      if (words > RESULT_LIMIT) words = RESULT_LIMIT;
      row = line_at / BLOCK_SIZE;
      for (int k = 0; k < words; k++) begin
        for (int i = 0; i < FLAG_WORD_BITS; i++) begin
          b        = k * FLAG_WORD_BITS + i;
          flags[i] = (b < blocks) && dirty_blocks[b];
        end
        if (keep)
          flag_words_due.push_back(make_word(row, k, flags, k + 1 == words, line_at == h - 1));
      end
      dirty_blocks = '0;
    end
    column_at++;
    if (column_at >= w) begin
      column_at = 0;
      line_at++;
      if (line_at >= h) line_at = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTED)
      $display("%0t ns: %s mismatch, got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (flag_words_due.size() == 0) begin
      report_mismatch("unrequested flag word", got.dirty_flags, 32'd0);
      return;
    end
    want = flag_words_due.pop_front();
    if (got.block_row != want.block_row)
      report_mismatch("block_row", got.block_row, want.block_row);
    if (got.word_index != want.word_index)
      report_mismatch("word_index", got.word_index, want.word_index);
    if (got.dirty_flags != want.dirty_flags)
      report_mismatch("dirty_flags", got.dirty_flags, want.dirty_flags);
    if (got.last_of_row != want.last_of_row)
      report_mismatch("last_of_row", got.last_of_row, want.last_of_row);
    if (got.frame_done != want.frame_done)
      report_mismatch("frame_done", got.frame_done, want.frame_done);
  endtask

  // one write, then a wait with the write enable low so back-to-back writes never collide
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_setting = value;
    else if (idx == REG_IMAGE_HEIGHT) height_setting = value;
    @(posedge clk);
  endtask

  // offer one request and hold it until taken; valid stays up for the caller
  task automatic send_pixel(input in_item_t px, input bit keep);
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(px, keep);
  endtask

  // mostly back to back, some short gaps, a few long ones
  task automatic sender_pause();
    int unsigned gap, roll;
    roll = $urandom_range(9);
    if (steady_feed || roll < 5) gap = 0;
    else if (roll < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block idle: every word in, plus the capture latency for rows in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (flag_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    script_step_t s;
    s           = '0;
    s.kind      = STEP_WRITE;
    s.reg_index = idx;
    s.reg_value = value;
    script.push_back(s);
  endtask

  // frame_start applies to the first pixel of the run only
  task automatic add_pixel(input logic [31:0] prev, input logic [31:0] cur, input logic fs,
                           input int unsigned reps, input int unsigned typed,
                           input out_item_t first, input out_item_t second);
    script_step_t s;
    s                      = '0;
    s.kind                 = STEP_PIXEL;
    s.pixel.previous_pixel = prev;
    s.pixel.current_pixel  = cur;
    s.pixel.frame_start    = fs;
    s.repeats              = 16'(reps);
    s.typed_count          = 2'(typed);
    s.typed_first          = first;
    s.typed_second         = second;
    script.push_back(s);
  endtask

  function automatic in_item_t random_pixel(input bit fs, input int unsigned change_pct);
    in_item_t px;
    px.previous_pixel = $urandom;
    px.current_pixel  = px.previous_pixel;
    px.frame_start    = fs;
    if ($urandom_range(99) < change_pct) begin
      if ($urandom_range(1) == 0) px.current_pixel = $urandom;
      else px.current_pixel = px.previous_pixel ^ (32'd1 << $urandom_range(31));
    end
    return px;
  endfunction

  // mostly small sizes so rows close quickly, sometimes the clamped extremes
  function automatic logic [CFG_W-1:0] pick_size(input int unsigned common_max);
    case ($urandom_range(11))
      0: return '0;
      1: return '1;
      2: return CFG_W'(MAX_WIDTH);
      3: return CFG_W'($urandom_range(MAX_WIDTH + 1, 8190));
      default: return CFG_W'($urandom_range(1, common_max));
    endcase
  endfunction

  task automatic random_phase();
    int unsigned n, change_pct;
    logic [CFG_W-1:0] w_pick, h_pick;
    bit fresh, fs;
    wait_idle();
    fresh  = ($urandom_range(3) != 0);
    w_pick = pick_size(48);
    h_pick = pick_size(8);
    n      = $urandom_range(15, 45);
    // size changes without frame_start land mid frame
    case ($urandom_range(3))
      0: begin
        write_reg(REG_IMAGE_WIDTH, w_pick);
        write_reg(REG_IMAGE_HEIGHT, h_pick);
      end
      1: write_reg(REG_IMAGE_WIDTH, w_pick);
      2: write_reg(REG_IMAGE_HEIGHT, h_pick);
      default: ;
    endcase
    if ($urandom_range(5) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
    case ($urandom_range(2))
      0: change_pct = 3;
      1: change_pct = 25;
      default: change_pct = 70;
    endcase
    steady_feed = ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      // occasional stray frame_start mid frame
      fs = (i == 0 && fresh) || ($urandom_range(79) == 0);
      send_pixel(random_pixel(fs, change_pct), 1'b1);
      sender_pause();
      random_pixels++;
    end
    steady_feed = 1'b0;
  endtask

  // result side: random back-pressure, calm stretches, one long hold-off
  initial begin : result_sink
    int unsigned stall_left, hold_left;
    bit calm;
    stall_left = 0;
    hold_left  = 0;
    calm       = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_word(out_data);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if ($urandom_range(199) == 0) calm = !calm;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(5) == 0) begin
          case ($urandom_range(19))
            0: stall_left = $urandom_range(20, 60);
            1, 2, 3, 4, 5: stall_left = $urandom_range(3, 8);
            default: stall_left = $urandom_range(1, 2);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t px;
    width_setting  = RESET_WIDTH;
    height_setting = RESET_HEIGHT;
    column_at      = 0;
    line_at        = 0;
    dirty_blocks   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero width counts as one pixel; the reset height keeps the first
    // block row from ending the frame
    add_write(REG_IMAGE_WIDTH, 0);
    add_pixel(32'h0000_0000, 32'h0000_0000, 1'b1, 15, 0, '0, '0);
    add_pixel(32'h0000_0003, 32'h0000_0004, 1'b0, 1, 1,
              make_word(0, 0, 32'h1, 1'b1, 1'b0), '0);
    // one-line frames: every pixel closes row and frame
    add_write(REG_IMAGE_HEIGHT, 1);
    add_pixel(32'h0000_0000, 32'h0000_0001, 1'b0, 1, 1,
              make_word(0, 0, 32'h1, 1'b1, 1'b1), '0);
    add_pixel(32'h0000_0005, 32'h0000_0005, 1'b0, 1, 1,
              make_word(0, 0, 32'h0, 1'b1, 1'b1), '0);
    // writes to unused indexes leave the sizes alone
    add_write(REG_SPARE_2, '1);
    add_write(REG_SPARE_3, 13'h0AAA);
    add_pixel(32'hFFFF_0000, 32'hFFFF_0001, 1'b1, 1, 1,
              make_word(0, 0, 32'h1, 1'b1, 1'b1), '0);
    // oversized width clamps high: a short run closes no row
    add_write(REG_IMAGE_WIDTH, '1);
    add_pixel(32'h0000_0000, 32'h8000_0000, 1'b1, 1, 0, '0, '0);
    add_pixel(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b0, 20, 0, '0, '0);
    // zero height counts as one line
    add_write(REG_IMAGE_WIDTH, 1);
    add_write(REG_IMAGE_HEIGHT, 0);
    add_pixel(32'h0000_0001, 32'h0000_0002, 1'b1, 1, 1,
              make_word(0, 0, 32'h1, 1'b1, 1'b1), '0);
    // oversized height clamps high: the first block row is not the last
    add_write(REG_IMAGE_HEIGHT, '1);
    add_pixel(32'h0000_0000, 32'h0000_0000, 1'b1, 15, 0, '0, '0);
    add_pixel(32'h0000_0003, 32'h0000_0004, 1'b0, 1, 1,
              make_word(0, 0, 32'h1, 1'b1, 1'b0), '0);
    // narrowed mid frame: column past the new width moves to the next line,
    // dirty flags from line 0 survive
    add_write(REG_IMAGE_HEIGHT, 3);
    add_write(REG_IMAGE_WIDTH, 5);
    add_pixel(32'h0000_0001, 32'h0000_0000, 1'b1, 1, 0, '0, '0);
    add_pixel(32'h5555_5555, 32'h5555_5555, 1'b0, 6, 0, '0, '0);
    add_write(REG_IMAGE_WIDTH, 2);
    add_pixel(32'h5555_5555, 32'h5555_5555, 1'b0, 1, 0, '0, '0);
    add_pixel(32'h5555_5555, 32'h5555_5555, 1'b0, 1, 1,
              make_word(0, 0, 32'h1, 1'b1, 1'b1), '0);
    // frame_start mid frame drops the flags gathered so far
    add_write(REG_IMAGE_WIDTH, 20);
    add_write(REG_IMAGE_HEIGHT, 1);
    add_pixel(32'h0000_0000, 32'h0000_0001, 1'b1, 1, 0, '0, '0);
    add_pixel(32'h0F0F_0F0F, 32'h0F0F_0F0F, 1'b0, 5, 0, '0, '0);
    add_pixel(32'h0F0F_0F0F, 32'h0F0F_0F0F, 1'b1, 1, 0, '0, '0);
    add_pixel(32'h0F0F_0F0F, 32'h0F0F_0F0F, 1'b0, 18, 0, '0, '0);
    add_pixel(32'h0000_0002, 32'h0000_0003, 1'b0, 1, 1,
              make_word(0, 0, 32'h2, 1'b1, 1'b1), '0);

    // walk the script; typed rows replace the prediction for their words
    foreach (script[s]) begin
      if (script[s].kind == STEP_WRITE) begin
        wait_idle();
        write_reg(script[s].reg_index, script[s].reg_value);
      end else begin
        for (int r = 0; r < script[s].repeats; r++) begin
          px = script[s].pixel;
          if (r != 0) px.frame_start = 1'b0;
          send_pixel(px, script[s].typed_count == 0);
          if (r + 1 == script[s].repeats && script[s].typed_count != 0) begin
            flag_words_due.push_back(script[s].typed_first);
            if (script[s].typed_count == 2) flag_words_due.push_back(script[s].typed_second);
          end
          sender_pause();
        end
      end
    end

    // every second pixel closes a row; the receiver holds off while requests pile up
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 2);
    hold_off_req = 1'b1;
    steady_feed  = 1'b1;
    repeat (HOLD_OFF_ITEMS) begin
      send_pixel(random_pixel(1'b0, 50), 1'b1);
      sender_pause();
    end
    steady_feed = 1'b0;

    while (random_pixels < RANDOM_ITEMS)
      random_phase();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #LIMIT_NS;
    $display("status: fail");
    $finish;
  end

endmodule
